>>> sv/lsm_pkg.sv
// Shared types and constants for the load/store multiple sequencer.
package lsm_pkg;

	localparam int unsigned NREGS = 16;
	localparam int unsigned IDX_W = 4;
	localparam int unsigned CNT_W = 5;

	localparam logic [IDX_W-1:0] PC_IDX = 4'd15;
	localparam logic [31:0] WORD_STEP = 32'd4;

	localparam logic [1:0] MODE_DA = 2'b00;
	localparam logic [1:0] MODE_IA = 2'b01;
	localparam logic [1:0] MODE_DB = 2'b10;
	localparam logic [1:0] MODE_IB = 2'b11;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_NULL
	} lsm_state_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic emit_null;
	} lsm_cmd_t;

	typedef struct packed {
		logic in_null;
		logic is_last;
	} lsm_sts_t;

	typedef struct packed {
		logic ld;
		logic ub;
		logic cpc;
		logic rc;
		logic wb;
	} lsm_flags_t;

endpackage

>>> sv/lsm_ctrl.sv
// Controller state machine: sequences item intake and result emission.
module lsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  lsm_pkg::lsm_sts_t sts,
	output lsm_pkg::lsm_cmd_t cmd
);
	import lsm_pkg::*;

	lsm_state_t state_q;
	lsm_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.in_null ? ST_NULL : ST_RUN;
				end
			end
			ST_RUN: begin
				if (out_free && sts.is_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_NULL: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		cmd.load      = 1'b0;
		cmd.emit      = 1'b0;
		cmd.emit_null = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_RUN:  cmd.emit = out_free;
			ST_NULL: cmd.emit_null = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit || cmd.emit_null) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> sv/lsm_datapath.sv
// Datapath: instruction registers, address stepping and the result register.
module lsm_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  lsm_pkg::lsm_cmd_t cmd,
	output lsm_pkg::lsm_sts_t sts,
	input  logic              cond_passed,
	input  logic              is_load,
	input  logic              s_bit,
	input  logic              writeback,
	input  logic [1:0]        mode,
	input  logic [15:0]       reg_list,
	input  logic [31:0]       base_value,
	input  logic              has_spsr,
	output logic              transfer_valid,
	output logic [3:0]        reg_index,
	output logic [31:0]       mem_address,
	output logic              load_op,
	output logic              user_bank,
	output logic              clear_pc_bit0,
	output logic              restore_cpsr,
	output logic              write_base,
	output logic [31:0]       new_base,
	output logic              last
);
	import lsm_pkg::*;

	logic [NREGS-1:0] pending_q;
	logic [31:0]      addr_q;
	logic [31:0]      final_q;
	lsm_flags_t       flags_q;

	logic [CNT_W-1:0] cnt;
	logic [31:0]      span;
	logic [31:0]      start_d;
	logic [31:0]      final_d;
	lsm_flags_t       flags_d;
	logic             pc_listed;

	logic [NREGS-1:0] low_bit;
	logic [NREGS-1:0] pending_next;
	logic [IDX_W-1:0] idx;
	logic             is_pc;

	always_comb begin
		cnt = '0;
		for (int i = 0; i < NREGS; i++) begin
			cnt = cnt + CNT_W'(reg_list[i]);
		end
	end

	assign span = {{(32-CNT_W-2){1'b0}}, cnt, 2'b00};

	always_comb begin
		unique case (mode)
			MODE_IA: begin
				start_d = base_value;
				final_d = base_value + span;
			end
			MODE_IB: begin
				start_d = base_value + WORD_STEP;
				final_d = base_value + span;
			end
			MODE_DA: begin
				final_d = base_value - span;
				start_d = final_d + WORD_STEP;
			end
			default: begin
				final_d = base_value - span;
				start_d = final_d;
			end
		endcase
	end

	assign pc_listed   = reg_list[PC_IDX];
	assign flags_d.ld  = is_load;
	assign flags_d.ub  = s_bit && (!is_load || !pc_listed);
	assign flags_d.cpc = is_load && !s_bit;
	assign flags_d.rc  = is_load && s_bit && has_spsr;
	assign flags_d.wb  = writeback;

	assign low_bit      = pending_q & (~pending_q + NREGS'(1));
	assign pending_next = pending_q & ~low_bit;

	always_comb begin
		idx = '0;
		for (int i = NREGS - 1; i >= 0; i--) begin
			if (pending_q[i]) begin
				idx = IDX_W'(i);
			end
		end
	end

	assign is_pc       = (idx == PC_IDX);
	assign sts.is_last = (pending_next == '0);
	assign sts.in_null = !cond_passed || (reg_list == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (cmd.load) begin
			pending_q <= reg_list;
		end else if (cmd.emit) begin
			pending_q <= pending_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			final_q <= '0;
			flags_q <= '0;
		end else if (cmd.load) begin
			addr_q  <= start_d;
			final_q <= final_d;
			flags_q <= flags_d;
		end else if (cmd.emit) begin
			addr_q <= addr_q + WORD_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transfer_valid <= 1'b0;
			reg_index      <= '0;
			mem_address    <= '0;
			load_op        <= 1'b0;
			user_bank      <= 1'b0;
			clear_pc_bit0  <= 1'b0;
			restore_cpsr   <= 1'b0;
			write_base     <= 1'b0;
			new_base       <= '0;
			last           <= 1'b0;
		end else if (cmd.emit) begin
			transfer_valid <= 1'b1;
			reg_index      <= idx;
			mem_address    <= addr_q;
			load_op        <= flags_q.ld;
			user_bank      <= flags_q.ub;
			clear_pc_bit0  <= flags_q.cpc && is_pc;
			restore_cpsr   <= flags_q.rc && is_pc;
			write_base     <= flags_q.wb && sts.is_last;
			new_base       <= sts.is_last ? final_q : '0;
			last           <= sts.is_last;
		end else if (cmd.emit_null) begin
			transfer_valid <= 1'b0;
			reg_index      <= '0;
			mem_address    <= '0;
			load_op        <= 1'b0;
			user_bank      <= 1'b0;
			clear_pc_bit0  <= 1'b0;
			restore_cpsr   <= 1'b0;
			write_base     <= 1'b0;
			new_base       <= '0;
			last           <= 1'b1;
		end
	end

endmodule

>>> sv/arm_load_store_multiple_sequencer.sv
// Top level of the load/store multiple sequencer.
// One decoded LDM/STM instruction is taken per item and expanded into one
// result per listed register, lowest register first at ascending word
// addresses; the last result carries the base writeback. The block first
// latches the instruction and computes start and final base, then emits one
// transfer per cycle from the register list scan while the output does not
// stall; a failed condition or empty list yields a single non-transfer result.
// Results sit in an output register, so the next item is taken while the last
// result of the previous one still waits; a stall on the output holds the
// sequencer in place.
module arm_load_store_multiple_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cond_passed,
	input  logic        is_load,
	input  logic        s_bit,
	input  logic        writeback,
	input  logic [1:0]  mode,
	input  logic [15:0] reg_list,
	input  logic [31:0] base_value,
	input  logic        has_spsr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        transfer_valid,
	output logic [3:0]  reg_index,
	output logic [31:0] mem_address,
	output logic        load_op,
	output logic        user_bank,
	output logic        clear_pc_bit0,
	output logic        restore_cpsr,
	output logic        write_base,
	output logic [31:0] new_base,
	output logic        last
);
	import lsm_pkg::*;

	lsm_cmd_t cmd;
	lsm_sts_t sts;

	lsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsm_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cond_passed    (cond_passed),
		.is_load        (is_load),
		.s_bit          (s_bit),
		.writeback      (writeback),
		.mode           (mode),
		.reg_list       (reg_list),
		.base_value     (base_value),
		.has_spsr       (has_spsr),
		.transfer_valid (transfer_valid),
		.reg_index      (reg_index),
		.mem_address    (mem_address),
		.load_op        (load_op),
		.user_bank      (user_bank),
		.clear_pc_bit0  (clear_pc_bit0),
		.restore_cpsr   (restore_cpsr),
		.write_base     (write_base),
		.new_base       (new_base),
		.last           (last)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sequencer took an item while busy");

	a_null_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !transfer_valid |-> last)
		else $error("non-transfer item not marked last");

	a_wb_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_base |-> last && transfer_valid)
		else $error("base writeback outside the last transfer");

	a_pc_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (clear_pc_bit0 || restore_cpsr) |-> reg_index == PC_IDX && load_op)
		else $error("PC flags on a non-PC transfer");

endmodule
